@@ hw/rtl/bbde_pkg.sv @@
// Shared types, constants and tables of the beam bending derivative unit.
package bbde_pkg;

    localparam int THETA_W   = 18;
    localparam int MOMENT_W  = 40;
    localparam int STRAIN_W  = 21;
    localparam int INERTIA_W = 40;
    localparam int MOD_W     = 20;
    localparam int SLOPE_W   = 32;
    localparam int RATE_W    = 48;
    localparam int EI_W      = MOD_W + INERTIA_W;
    localparam int IN_W      = 160;
    localparam int OUT_W     = 144;

    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_W     = 34;
    localparam int MAG_W        = CORDIC_W - 1;
    localparam int DEN_W        = EI_W + MAG_W;
    localparam int ROM_IDX_W    = 6;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CORDIC_W-1:0] PI_Q30      = 34'sd3373259426;

    localparam logic [13:0] STRAIN_STEP = 14'd10000;
    // floor(s / 10000) = (s * IDX_RECIP) >> IDX_SHIFT for s below 2^20.
    localparam logic [20:0] IDX_RECIP = 21'd1717987;
    localparam int          IDX_SHIFT = 34;
    // floor(p / 10000) = (p * QUO_RECIP) >> QUO_SHIFT for p below 2^32.
    localparam logic [32:0] QUO_RECIP = 33'd7036874418;
    localparam int          QUO_SHIFT = 46;

    localparam logic [MOD_W-1:0]   MOD_RESET = 20'd215800;
    localparam logic [SLOPE_W-1:0] SLOPE_MAX = 32'h7FFF_FFFF;
    localparam logic [SLOPE_W-1:0] SLOPE_MIN = 32'h8000_0000;
    localparam logic [RATE_W-1:0]  RATE_MAX  = 48'h7FFF_FFFF_FFFF;
    localparam logic [RATE_W-1:0]  RATE_MIN  = 48'h8000_0000_0000;

    typedef struct packed {
        logic signed [THETA_W-1:0]  theta;
        logic signed [MOMENT_W-1:0] moment;
        logic [MOMENT_W-1:0]        shear;
    } mod_side_t;

    typedef struct packed {
        logic signed [MOMENT_W-1:0] moment;
        logic [MOMENT_W-1:0]        shear;
        logic [MOD_W-1:0]           modulus;
        logic [EI_W-1:0]            ei;
    } cordic_side_t;

    typedef struct packed {
        logic [MOMENT_W-1:0] moment_mag;
        logic [DEN_W-1:0]    den;
        logic                moment_zero;
        logic                den_zero;
        logic                rate_neg;
        logic [MOMENT_W-1:0] shear;
        logic [MOD_W-1:0]    modulus;
        logic                y_neg;
        logic                x_neg;
        logic                x_zero;
    } slope_side_t;

    typedef struct packed {
        logic [SLOPE_W-1:0]  slope;
        logic                slope_sat;
        logic                moment_zero;
        logic                den_zero;
        logic                rate_neg;
        logic [MOMENT_W-1:0] shear;
        logic [MOD_W-1:0]    modulus;
    } rate_side_t;

    function automatic logic signed [CORDIC_W-1:0] atan_q30(input int i);
        logic signed [CORDIC_W-1:0] a;
        case (i)
            0:       a = 34'sd843314857;
            1:       a = 34'sd497837829;
            2:       a = 34'sd263043837;
            3:       a = 34'sd133525159;
            4:       a = 34'sd67021687;
            5:       a = 34'sd33543516;
            6:       a = 34'sd16775851;
            7:       a = 34'sd8388437;
            8:       a = 34'sd4194283;
            9:       a = 34'sd2097149;
            default: a = CORDIC_W'(64'sd1 <<< (30 - i));
        endcase
        return a;
    endfunction

    function automatic logic [MOD_W-1:0] mod_rom(input logic [ROM_IDX_W-1:0] a);
        logic [MOD_W-1:0] v;
        case (a)
            6'd0:    v = 20'd215800;
            6'd1:    v = 20'd215800;
            6'd2:    v = 20'd179500;
            6'd3:    v = 20'd138100;
            6'd4:    v = 20'd94300;
            6'd5:    v = 20'd59500;
            6'd6:    v = 20'd39700;
            6'd7:    v = 20'd28200;
            6'd8:    v = 20'd21100;
            6'd9:    v = 20'd17000;
            6'd10:   v = 20'd14300;
            6'd11:   v = 20'd12700;
            6'd12:   v = 20'd11000;
            6'd13:   v = 20'd10600;
            6'd14:   v = 20'd10000;
            6'd15:   v = 20'd9700;
            6'd16:   v = 20'd9600;
            6'd17:   v = 20'd8600;
            6'd18:   v = 20'd9400;
            6'd19:   v = 20'd8600;
            default: v = 20'd8500;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/bbde_modulus.sv @@
// Modulus selection and interpolation over strain, followed by the E times I product.
module bbde_modulus
    import bbde_pkg::*;
#(
    parameter int TABLE_POINTS = 21,
    parameter int SW = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [STRAIN_W-1:0] strain,
    input  logic [MOD_W-1:0]           young_modulus,
    input  logic [INERTIA_W-1:0]       inertia,
    input  logic [SW-1:0]              side_in,
    output logic                       out_valid,
    output logic [MOD_W-1:0]           modulus,
    output logic [EI_W-1:0]            ei,
    output logic [SW-1:0]              side_out
);

    typedef enum logic [1:0] {KIND_ZERO, KIND_LOW, KIND_HIGH, KIND_MID} kind_t;

    localparam int NS = 8;
    localparam logic [19:0] TOP_STRAIN = 20'((TABLE_POINTS - 1) * 10000);
    localparam logic [ROM_IDX_W-1:0] LAST_IDX = ROM_IDX_W'(TABLE_POINTS - 1);

    logic                 v_reg       [0:NS-1];
    kind_t                kind_reg    [0:NS-1];
    logic [MOD_W-1:0]     ym_reg      [0:NS-1];
    logic [INERTIA_W-1:0] inertia_reg [0:NS-1];
    logic [SW-1:0]        side_reg    [0:NS-1];

    logic [19:0]           s0_reg, s1_reg;
    logic [ROM_IDX_W-1:0]  idx1_reg;
    logic [13:0]           f2_reg;
    logic [MOD_W-1:0]      y0_2_reg, y0_3_reg, y0_4_reg;
    logic signed [20:0]    diff2_reg;
    logic                  neg3_reg, neg4_reg;
    logic [31:0]           mag3_reg;
    logic [MOD_W-1:0]      q4_reg;
    logic [MOD_W-1:0]      e5_reg, e6_reg, e7_reg;
    logic [39:0]           plo6_reg, phi6_reg;
    logic [EI_W-1:0]       ei7_reg;

    kind_t                 kind_in;
    logic [40:0]           idx_prod;
    logic [19:0]           idx_base;
    logic signed [35:0]    frac_prod;
    logic [64:0]           quo_prod;
    logic [MOD_W-1:0]      e5_next;

    always_comb
    begin
        if (strain == '0)
            kind_in = KIND_ZERO;
        else if (strain[STRAIN_W-1])
            kind_in = KIND_LOW;
        else if (strain[19:0] >= TOP_STRAIN)
            kind_in = KIND_HIGH;
        else
            kind_in = KIND_MID;
    end

    assign idx_prod  = 41'(s0_reg) * 41'(IDX_RECIP);
    assign idx_base  = 20'(idx1_reg) * 20'(STRAIN_STEP);
    assign frac_prod = 36'($signed({1'b0, f2_reg})) * 36'(diff2_reg);
    assign quo_prod  = 65'(mag3_reg) * 65'(QUO_RECIP);

    always_comb
    begin
        case (kind_reg[4])
            KIND_ZERO: e5_next = ym_reg[4];
            KIND_LOW:  e5_next = mod_rom('0);
            KIND_HIGH: e5_next = mod_rom(LAST_IDX);
            default:   e5_next = neg4_reg ? (y0_4_reg - q4_reg) : (y0_4_reg + q4_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NS; p++)
                v_reg[p] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int p = 1; p < NS; p++)
                v_reg[p] <= v_reg[p-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg[0]    <= kind_in;
            ym_reg[0]      <= young_modulus;
            inertia_reg[0] <= inertia;
            side_reg[0]    <= side_in;
            for (int p = 1; p < NS; p++)
            begin
                kind_reg[p]    <= kind_reg[p-1];
                ym_reg[p]      <= ym_reg[p-1];
                inertia_reg[p] <= inertia_reg[p-1];
                side_reg[p]    <= side_reg[p-1];
            end
            s0_reg    <= strain[19:0];
            idx1_reg  <= idx_prod[IDX_SHIFT+ROM_IDX_W-1:IDX_SHIFT];
            s1_reg    <= s0_reg;
            f2_reg    <= 14'(s1_reg - idx_base);
            y0_2_reg  <= mod_rom(idx1_reg);
            diff2_reg <= $signed({1'b0, mod_rom(idx1_reg + 1'b1)})
                         - $signed({1'b0, mod_rom(idx1_reg)});
            neg3_reg  <= frac_prod[35];
            mag3_reg  <= frac_prod[35] ? 32'(-frac_prod) : 32'(frac_prod);
            y0_3_reg  <= y0_2_reg;
            q4_reg    <= quo_prod[QUO_SHIFT+MOD_W-1:QUO_SHIFT];
            neg4_reg  <= neg3_reg;
            y0_4_reg  <= y0_3_reg;
            e5_reg    <= e5_next;
            plo6_reg  <= 40'(e5_reg) * 40'(inertia_reg[5][19:0]);
            phi6_reg  <= 40'(e5_reg) * 40'(inertia_reg[5][39:20]);
            e6_reg    <= e5_reg;
            ei7_reg   <= {phi6_reg, 20'b0} + EI_W'(plo6_reg);
            e7_reg    <= e6_reg;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign modulus   = e7_reg;
    assign ei        = ei7_reg;
    assign side_out  = side_reg[NS-1];

endmodule

@@ hw/rtl/bbde_cordic.sv @@
// Rotation CORDIC pipeline, one iteration per stage, giving cosine and sine in Q4.30.
module bbde_cordic
    import bbde_pkg::*;
#(
    parameter int SW = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [THETA_W-1:0]  theta,
    input  logic [SW-1:0]              side_in,
    output logic                       out_valid,
    output logic signed [CORDIC_W-1:0] cos_out,
    output logic signed [CORDIC_W-1:0] sin_out,
    output logic [SW-1:0]              side_out
);

    localparam int N = CORDIC_ITERS;

    logic                       v_reg    [0:N+1];
    logic signed [CORDIC_W-1:0] x_reg    [0:N];
    logic signed [CORDIC_W-1:0] y_reg    [0:N];
    logic signed [CORDIC_W-1:0] z_reg    [0:N];
    logic                       neg_reg  [0:N];
    logic [SW-1:0]              side_reg [0:N+1];
    logic signed [CORDIC_W-1:0] xo_reg, yo_reg;

    logic signed [CORDIC_W-1:0] z_in;

    assign z_in = {{(CORDIC_W-THETA_W-14){theta[THETA_W-1]}}, theta, 14'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= N + 1; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= N + 1; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Fold angles beyond a quarter turn back by pi and flip the result.
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            side_reg[0] <= side_in;
            if (z_in > HALF_PI_Q30)
            begin
                z_reg[0]   <= z_in - PI_Q30;
                neg_reg[0] <= 1'b1;
            end
            else if (z_in < -HALF_PI_Q30)
            begin
                z_reg[0]   <= z_in + PI_Q30;
                neg_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0]   <= z_in;
                neg_reg[0] <= 1'b0;
            end
            for (int i = 0; i < N; i++)
            begin
                side_reg[i+1] <= side_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
            end
            side_reg[N+1] <= side_reg[N];
            xo_reg <= neg_reg[N] ? -x_reg[N] : x_reg[N];
            yo_reg <= neg_reg[N] ? -y_reg[N] : y_reg[N];
        end
    end

    assign out_valid = v_reg[N+1];
    assign cos_out   = xo_reg;
    assign sin_out   = yo_reg;
    assign side_out  = side_reg[N+1];

endmodule

@@ hw/rtl/bbde_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
module bbde_divider
    import bbde_pkg::*;
#(
    parameter int NW = 49,
    parameter int DW = 33,
    parameter int QW = 32,
    parameter int SW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic          ovf,
    output logic [SW-1:0] side_out
);

    localparam int HW = NW - QW;
    localparam int XW = (HW > DW) ? HW : DW;

    logic          v_reg    [0:QW];
    logic [DW-1:0] rem_reg  [0:QW];
    logic [QW-1:0] low_reg  [0:QW];
    logic [QW-1:0] q_reg    [0:QW];
    logic [DW-1:0] d_reg    [0:QW];
    logic          ovf_reg  [0:QW];
    logic [SW-1:0] side_reg [0:QW];

    logic [XW-1:0] hi_w, d_w;
    logic [DW+1:0] trial [0:QW-1];

    assign hi_w = XW'(num >> QW);
    assign d_w  = XW'(den);

    always_comb
    begin
        for (int k = 0; k < QW; k++)
            trial[k] = {1'b0, rem_reg[k], low_reg[k][QW-1-k]} - {2'b00, d_reg[k]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= QW; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // A high part at or above the divisor means the quotient needs more than QW bits.
            rem_reg[0]  <= DW'(hi_w);
            ovf_reg[0]  <= hi_w >= d_w;
            low_reg[0]  <= num[QW-1:0];
            q_reg[0]    <= '0;
            d_reg[0]    <= den;
            side_reg[0] <= side_in;
            for (int k = 0; k < QW; k++)
            begin
                if (trial[k][DW+1])
                    rem_reg[k+1] <= {rem_reg[k][DW-2:0], low_reg[k][QW-1-k]};
                else
                    rem_reg[k+1] <= trial[k][DW-1:0];
                q_reg[k+1]    <= {q_reg[k][QW-2:0], ~trial[k][DW+1]};
                low_reg[k+1]  <= low_reg[k];
                d_reg[k+1]    <= d_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign quo       = q_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

@@ hw/rtl/beam_bending_derivative_eval_unit.sv @@
// Throughput: one beat per cycle while the output register is not stalled;
// every stage is a register and all stages advance together.
// A stalled output register holds the whole pipeline, so nothing is dropped or repeated.
// The CORDIC and the two bit-per-stage dividers set the depth.
// Reset (rst_n, asynchronous, active low) clears all valid bits and loads modulus 215800.
module beam_bending_derivative_eval_unit
    import bbde_pkg::*;
#(
    parameter int TABLE_POINTS = 21
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // theta[17:0], moment[57:18], shear[97:58], strain[118:98], inertia[158:119], zero pad
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // slope_rate[31:0], angle_rate[79:32], moment_rate[119:80], modulus_used[139:120],
    // saturated[140], zero pad
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [MOD_W-1:0] cfg_data
);

    logic             adv;
    logic [MOD_W-1:0] young_modulus_reg;

    mod_side_t        mod_side_in, mod_side_out;
    logic             mod_valid;
    logic [MOD_W-1:0] mod_e;
    logic [EI_W-1:0]  mod_ei;

    cordic_side_t               cor_side_in, cor_side_out;
    logic                       cor_valid;
    logic signed [CORDIC_W-1:0] cor_x, cor_y;

    logic                c1_valid_reg;
    logic [MAG_W-1:0]    c1_xmag_reg, c1_ymag_reg;
    logic                c1_xneg_reg, c1_yneg_reg, c1_xzero_reg, c1_eizero_reg;
    logic [62:0]         c1_plo_reg, c1_phi_reg;
    logic [MOMENT_W-1:0] c1_mmag_reg, c1_shear_reg;
    logic                c1_mneg_reg, c1_mzero_reg;
    logic [MOD_W-1:0]    c1_e_reg;
    logic [MAG_W-1:0]    xmag, ymag;

    slope_side_t        sd_side_in, sd_side_out;
    logic               sd_valid, sd_ovf;
    logic [SLOPE_W-1:0] sd_q;

    rate_side_t        rd_side_in, rd_side_out;
    logic              rd_valid, rd_ovf;
    logic [RATE_W-1:0] rd_q;

    logic               slope_neg, slope_over;
    logic [SLOPE_W-1:0] slope_val;
    logic               slope_sat;
    logic [SLOPE_W:0]   slope_lim;

    logic [RATE_W:0]   rate_lim;
    logic [RATE_W-1:0] rate_val;
    logic              rate_sat;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            young_modulus_reg <= MOD_RESET;
        else if (cfg_valid)
            young_modulus_reg <= cfg_data;
    end

    assign mod_side_in.theta  = s_tdata[17:0];
    assign mod_side_in.moment = s_tdata[57:18];
    assign mod_side_in.shear  = s_tdata[97:58];

    bbde_modulus #(
        .TABLE_POINTS (TABLE_POINTS),
        .SW           ($bits(mod_side_t))
    ) u_modulus (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (adv),
        .in_valid      (s_tvalid),
        .strain        (s_tdata[118:98]),
        .young_modulus (young_modulus_reg),
        .inertia       (s_tdata[158:119]),
        .side_in       (mod_side_in),
        .out_valid     (mod_valid),
        .modulus       (mod_e),
        .ei            (mod_ei),
        .side_out      (mod_side_out)
    );

    assign cor_side_in.moment  = mod_side_out.moment;
    assign cor_side_in.shear   = mod_side_out.shear;
    assign cor_side_in.modulus = mod_e;
    assign cor_side_in.ei      = mod_ei;

    bbde_cordic #(
        .SW ($bits(cordic_side_t))
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (mod_valid),
        .theta     (mod_side_out.theta),
        .side_in   (cor_side_in),
        .out_valid (cor_valid),
        .cos_out   (cor_x),
        .sin_out   (cor_y),
        .side_out  (cor_side_out)
    );

    assign xmag = cor_x[CORDIC_W-1] ? MAG_W'(-cor_x) : cor_x[MAG_W-1:0];
    assign ymag = cor_y[CORDIC_W-1] ? MAG_W'(-cor_y) : cor_y[MAG_W-1:0];

    // E*I times |cos| is split in two partial products, summed on the way into the divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c1_valid_reg <= 1'b0;
        else if (adv)
            c1_valid_reg <= cor_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_xmag_reg   <= xmag;
            c1_ymag_reg   <= ymag;
            c1_xneg_reg   <= cor_x[CORDIC_W-1];
            c1_yneg_reg   <= cor_y[CORDIC_W-1];
            c1_xzero_reg  <= cor_x == '0;
            c1_eizero_reg <= cor_side_out.ei == '0;
            c1_plo_reg    <= 63'(cor_side_out.ei[29:0]) * 63'(xmag);
            c1_phi_reg    <= 63'(cor_side_out.ei[59:30]) * 63'(xmag);
            c1_mneg_reg   <= cor_side_out.moment[MOMENT_W-1];
            c1_mzero_reg  <= cor_side_out.moment == '0;
            c1_mmag_reg   <= cor_side_out.moment[MOMENT_W-1] ? MOMENT_W'(-cor_side_out.moment)
                                                             : cor_side_out.moment;
            c1_shear_reg  <= cor_side_out.shear;
            c1_e_reg      <= cor_side_out.modulus;
        end
    end

    assign sd_side_in.moment_mag  = c1_mmag_reg;
    assign sd_side_in.den         = {c1_phi_reg, 30'b0} + DEN_W'(c1_plo_reg);
    assign sd_side_in.moment_zero = c1_mzero_reg;
    assign sd_side_in.den_zero    = c1_eizero_reg || c1_xzero_reg;
    assign sd_side_in.rate_neg    = c1_mneg_reg != c1_xneg_reg;
    assign sd_side_in.shear       = c1_shear_reg;
    assign sd_side_in.modulus     = c1_e_reg;
    assign sd_side_in.y_neg       = c1_yneg_reg;
    assign sd_side_in.x_neg       = c1_xneg_reg;
    assign sd_side_in.x_zero      = c1_xzero_reg;

    bbde_divider #(
        .NW (MAG_W + 16),
        .DW (MAG_W),
        .QW (SLOPE_W),
        .SW ($bits(slope_side_t))
    ) u_slope_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (c1_valid_reg),
        .num       ({c1_ymag_reg, 16'b0}),
        .den       (c1_xmag_reg),
        .side_in   (sd_side_in),
        .out_valid (sd_valid),
        .quo       (sd_q),
        .ovf       (sd_ovf),
        .side_out  (sd_side_out)
    );

    // Tangent: a zero cosine saturates toward the sign of the sine.
    always_comb
    begin
        slope_neg  = sd_side_out.y_neg != sd_side_out.x_neg;
        slope_lim  = slope_neg ? {1'b0, SLOPE_MIN} : {1'b0, SLOPE_MAX};
        slope_over = sd_ovf || ({1'b0, sd_q} > slope_lim);
        if (sd_side_out.x_zero)
        begin
            slope_sat = 1'b1;
            slope_val = sd_side_out.y_neg ? SLOPE_MIN : SLOPE_MAX;
        end
        else if (slope_over)
        begin
            slope_sat = 1'b1;
            slope_val = slope_neg ? SLOPE_MIN : SLOPE_MAX;
        end
        else
        begin
            slope_sat = 1'b0;
            slope_val = slope_neg ? -sd_q : sd_q;
        end
    end

    assign rd_side_in.slope       = slope_val;
    assign rd_side_in.slope_sat   = slope_sat;
    assign rd_side_in.moment_zero = sd_side_out.moment_zero;
    assign rd_side_in.den_zero    = sd_side_out.den_zero;
    assign rd_side_in.rate_neg    = sd_side_out.rate_neg;
    assign rd_side_in.shear       = sd_side_out.shear;
    assign rd_side_in.modulus     = sd_side_out.modulus;

    bbde_divider #(
        .NW (MOMENT_W + 62),
        .DW (DEN_W),
        .QW (RATE_W),
        .SW ($bits(rate_side_t))
    ) u_rate_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sd_valid),
        .num       ({sd_side_out.moment_mag, 62'b0}),
        .den       (sd_side_out.den),
        .side_in   (rd_side_in),
        .out_valid (rd_valid),
        .quo       (rd_q),
        .ovf       (rd_ovf),
        .side_out  (rd_side_out)
    );

    always_comb
    begin
        rate_lim = rd_side_out.rate_neg ? {1'b0, RATE_MIN} : {1'b0, RATE_MAX};
        if (rd_side_out.moment_zero)
        begin
            rate_sat = 1'b0;
            rate_val = '0;
        end
        else if (rd_side_out.den_zero || rd_ovf || ({1'b0, rd_q} > rate_lim))
        begin
            rate_sat = 1'b1;
            rate_val = rd_side_out.rate_neg ? RATE_MIN : RATE_MAX;
        end
        else
        begin
            rate_sat = 1'b0;
            rate_val = rd_side_out.rate_neg ? -rd_q : rd_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= rd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= {3'b000, rd_side_out.slope_sat || rate_sat, rd_side_out.modulus,
                             rd_side_out.shear, rate_val, rd_side_out.slope};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    // A raised flag always comes with a value pinned at one of its limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[140] |->
            m_tdata[31:0] == SLOPE_MAX || m_tdata[31:0] == SLOPE_MIN ||
            m_tdata[79:32] == RATE_MAX || m_tdata[79:32] == RATE_MIN)
        else $error("saturation flag without a clipped value");

    // A new result beat appears only on a cycle where the pipeline advanced.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tready))
        else $error("result beat appeared during a stall");

    // The output padding bits stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[143:141] == 3'b000)
        else $error("nonzero padding in result beat");
`endif

endmodule
